// ----- sv/rv32i_subset_execute_assert.svh -----
// Assertion macros shared by the execute block.
// Relies on i_clk and i_rst_n in the module that expands them.
`ifndef RV32I_SUBSET_EXECUTE_ASSERT_SVH
`define RV32I_SUBSET_EXECUTE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RVSE_ASSERT_COMB(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RVSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rvse_pkg.sv -----
// Shared types, encodings and sizes for the RV32I subset execute block.
// No dependencies.
`timescale 1ns / 1ps

package rvse_pkg;

    localparam int XLEN       = 32;
    localparam int REGS       = 32;
    localparam int REG_AW     = 5;
    // Word count of the data memory; a power of two so the index is a part-select.
    localparam int DATA_WORDS = 1024;
    localparam int DMEM_AW    = $clog2(DATA_WORDS);

    localparam logic [XLEN-1:0] START_ADDR_RST = 32'h0000_0000;
    localparam logic [XLEN-1:0] MISALIGN_BIT   = 32'h0000_0002;
    localparam logic [XLEN-1:0] PC_ALIGN_MASK  = 32'hFFFF_FFFE;
    localparam logic [XLEN-1:0] LANE_KEEP_MASK = 32'hFFFF_FF00;
    localparam logic [XLEN-1:0] BYTE_MASK      = 32'h0000_00FF;
    localparam logic [XLEN-1:0] UIMM_MASK      = 32'hFFFF_F000;
    localparam logic [XLEN-1:0] INSTR_BYTES    = 32'h0000_0004;

    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;

    localparam logic [2:0] F3_ADDI = 3'd0;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_JALR = 3'd0;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_SW   = 3'd2;
    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [6:0] F7_BASE = 7'd0;

    typedef enum logic [1:0] {
        ST_DONE        = 2'd0,
        ST_MISALIGNED  = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MOP_NONE,
        MOP_LW,
        MOP_SW,
        MOP_SB
    } t_mem_op;

    // Everything one instruction carries out of execute.
    typedef struct packed {
        logic [XLEN-1:0]   instr_address;
        logic [XLEN-1:0]   next_address;
        t_status           status;
        logic              dest_write;
        logic [REG_AW-1:0] dest_index;
        logic [XLEN-1:0]   dest_value;
        t_mem_op           mem_op;
        logic [XLEN-1:0]   mem_address;
        logic [XLEN-1:0]   store_data;
    } t_exec;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_rf_wr;

    typedef struct packed {
        logic               en;
        logic [DMEM_AW-1:0] addr;
        logic [XLEN-1:0]    data;
    } t_dm_wr;

endpackage

// ----- sv/rvse_regfile.sv -----
// Register file: 32x32 RAM, two registered read ports, one write port.
// Uses rvse_pkg. Valid bits give all-zero contents after reset.
`timescale 1ns / 1ps

module rvse_regfile import rvse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [REG_AW-1:0] i_rs1_addr,
    input  logic [REG_AW-1:0] i_rs2_addr,
    input  t_rf_wr            i_wr,
    output logic [XLEN-1:0]   o_rs1_data,
    output logic [XLEN-1:0]   o_rs2_data
);

    logic [XLEN-1:0] r_mem [REGS];
    logic [REGS-1:0] r_valid;
    logic [XLEN-1:0] r_rd1, r_rd2, r_byp_data;
    logic            r_vld1, r_vld2, r_byp1, r_byp2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // write in the read cycle wins over the old contents
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd1      <= r_mem[i_rs1_addr];
            r_rd2      <= r_mem[i_rs2_addr];
            r_vld1     <= r_valid[i_rs1_addr];
            r_vld2     <= r_valid[i_rs2_addr];
            r_byp1     <= i_wr.en && (i_wr.addr == i_rs1_addr);
            r_byp2     <= i_wr.en && (i_wr.addr == i_rs2_addr);
            r_byp_data <= i_wr.data;
        end
    end

    assign o_rs1_data = r_byp1 ? r_byp_data : (r_vld1 ? r_rd1 : '0);
    assign o_rs2_data = r_byp2 ? r_byp_data : (r_vld2 ? r_rd2 : '0);

endmodule

// ----- sv/rvse_dmem.sv -----
// Data memory: DATA_WORDS x 32 RAM, one registered read, one write port.
// Uses rvse_pkg. Zeroes itself after reset, one word per cycle.
`timescale 1ns / 1ps

module rvse_dmem import rvse_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [DMEM_AW-1:0] i_rd_addr,
    input  t_dm_wr             i_wr,
    output logic [XLEN-1:0]    o_rd_data,
    output logic               o_busy
);

    localparam logic [DMEM_AW-1:0] LAST_WORD = DMEM_AW'(DATA_WORDS - 1);

    logic [XLEN-1:0]    r_mem [DATA_WORDS];
    logic               r_clr_busy;
    logic [DMEM_AW-1:0] r_clr_idx;
    logic [XLEN-1:0]    r_rdata, r_byp_data;
    logic               r_byp;
    logic               wr_en;
    logic [DMEM_AW-1:0] wr_addr;
    logic [XLEN-1:0]    wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == LAST_WORD) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    assign wr_en   = r_clr_busy || i_wr.en;
    assign wr_addr = r_clr_busy ? r_clr_idx : i_wr.addr;
    assign wr_data = r_clr_busy ? '0 : i_wr.data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata    <= r_mem[i_rd_addr];
            r_byp      <= i_wr.en && (i_wr.addr == i_rd_addr);
            r_byp_data <= i_wr.data;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rdata;
    assign o_busy    = r_clr_busy;

endmodule

// ----- sv/rvse_exec.sv -----
// Decode and execute for one instruction: immediates, ALU, targets, next PC.
// Uses rvse_pkg. Load data is filled in later by the memory stage.
`timescale 1ns / 1ps

module rvse_exec import rvse_pkg::*; (
    input  logic [XLEN-1:0] i_instruction,
    input  logic [XLEN-1:0] i_pc,
    input  logic [XLEN-1:0] i_rs1_data,
    input  logic [XLEN-1:0] i_rs2_data,
    output t_exec           o_exec
);

    logic [6:0]        opc, f7;
    logic [2:0]        f3;
    logic [REG_AW-1:0] rd;
    logic [XLEN-1:0]   imm_i, imm_s, imm_j, imm_b, link;
    logic [XLEN-1:0]   tgt, val, maddr, next;
    logic              wr;
    t_status           status;
    t_mem_op           mop;

    assign opc   = i_instruction[6:0];
    assign rd    = i_instruction[11:7];
    assign f3    = i_instruction[14:12];
    assign f7    = i_instruction[31:25];
    assign imm_i = {{20{i_instruction[31]}}, i_instruction[31:20]};
    assign imm_s = {{20{i_instruction[31]}}, i_instruction[31:25], i_instruction[11:7]};
    assign imm_j = {{11{i_instruction[31]}}, i_instruction[31], i_instruction[19:12],
                    i_instruction[20], i_instruction[30:21], 1'b0};
    assign imm_b = {{19{i_instruction[31]}}, i_instruction[31], i_instruction[7],
                    i_instruction[30:25], i_instruction[11:8], 1'b0};
    assign link  = i_pc + INSTR_BYTES;

    always_comb begin
        wr     = 1'b0;
        val    = '0;
        maddr  = '0;
        tgt    = '0;
        next   = link;
        status = ST_DONE;
        mop    = MOP_NONE;
        case (opc)
            OPC_OP_IMM: begin
                if (f3 == F3_ADDI) begin
                    wr  = 1'b1;
                    val = i_rs1_data + imm_i;
                end else begin
                    status = ST_UNSUPPORTED;
                end
            end
            OPC_LUI: begin
                wr  = 1'b1;
                val = i_instruction & UIMM_MASK;
            end
            OPC_AUIPC: begin
                wr  = 1'b1;
                val = i_pc + (i_instruction & UIMM_MASK);
            end
            OPC_OP: begin
                if (f7 == F7_BASE && f3 == F3_XOR) begin
                    wr  = 1'b1;
                    val = i_rs1_data ^ i_rs2_data;
                end else if (f7 == F7_BASE && f3 == F3_SLTU) begin
                    wr  = 1'b1;
                    val = {{(XLEN-1){1'b0}}, (i_rs1_data < i_rs2_data)};
                end else begin
                    status = ST_UNSUPPORTED;
                end
            end
            OPC_JAL: begin
                tgt = i_pc + imm_j;
                if ((tgt & MISALIGN_BIT) != '0) begin
                    status = ST_MISALIGNED;
                end else begin
                    wr   = 1'b1;
                    val  = link;
                    next = tgt;
                end
            end
            OPC_JALR: begin
                if (f3 == F3_JALR) begin
                    tgt = i_rs1_data + imm_i;
                    if ((tgt & MISALIGN_BIT) != '0) begin
                        status = ST_MISALIGNED;
                    end else begin
                        wr   = 1'b1;
                        val  = link;
                        next = tgt & PC_ALIGN_MASK;
                    end
                end else begin
                    status = ST_UNSUPPORTED;
                end
            end
            OPC_BRANCH: begin
                if (f3 == F3_BEQ) begin
                    // target checked even when the branch falls through
                    tgt = i_pc + imm_b;
                    if ((tgt & MISALIGN_BIT) != '0) begin
                        status = ST_MISALIGNED;
                    end else if (i_rs1_data == i_rs2_data) begin
                        next = tgt;
                    end
                end else begin
                    status = ST_UNSUPPORTED;
                end
            end
            OPC_LOAD: begin
                if (f3 == F3_LW) begin
                    wr    = 1'b1;
                    maddr = i_rs1_data + imm_i;
                    mop   = MOP_LW;
                end else begin
                    status = ST_UNSUPPORTED;
                end
            end
            OPC_STORE: begin
                if (f3 == F3_SW) begin
                    maddr = i_rs1_data + imm_s;
                    mop   = MOP_SW;
                end else if (f3 == F3_SB) begin
                    maddr = i_rs1_data + imm_s;
                    mop   = MOP_SB;
                end else begin
                    status = ST_UNSUPPORTED;
                end
            end
            default: begin
                status = ST_UNSUPPORTED;
            end
        endcase

        o_exec.instr_address = i_pc;
        o_exec.store_data    = i_rs2_data;
        if (status != ST_DONE) begin
            o_exec.next_address = i_pc;
            o_exec.status       = status;
            o_exec.dest_write   = 1'b0;
            o_exec.dest_index   = '0;
            o_exec.dest_value   = '0;
            o_exec.mem_op       = MOP_NONE;
            o_exec.mem_address  = '0;
        end else begin
            o_exec.next_address = next;
            o_exec.status       = status;
            o_exec.dest_write   = wr && (rd != '0);
            o_exec.dest_index   = wr ? rd : '0;
            o_exec.dest_value   = (wr && (rd != '0)) ? val : '0;
            o_exec.mem_op       = mop;
            o_exec.mem_address  = maddr;
        end
    end

endmodule

// ----- sv/rv32i_subset_execute.sv -----
// Top level of the RV32I subset execute block: pipeline, forwarding, output.
// Uses rvse_pkg, rvse_regfile, rvse_dmem, rvse_exec and the assertion header.
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+---------------------------------------
//   cfg     | in  | i_cfg_we (no wait)        | i_cfg_data = start_address
//   in      | in  | i_in_valid / o_in_ready   | i_instruction
//   out     | out | o_out_valid / i_out_ready | o_instr_address .. o_mem_address
//
// Flow: one item per cycle sustained while the output register is drained; a result
//   sits in the output register after its item passes execute, then the memory stage.
// The loop that bounds the clock is load forwarding: data memory read port ->
//   operand mux -> address adder of the following item -> memory read address.
// Reset: PC takes start_address; the data memory runs a clearing pass over
//   all DATA_WORDS (1024) words, during which no item is accepted.
// Stalls: a full output register holds the memory stage, which holds execute;
//   input is still taken while execute is empty.
`timescale 1ns / 1ps
`include "rv32i_subset_execute_assert.svh"

module rv32i_subset_execute import rvse_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [31:0]     i_instruction,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [31:0]     o_instr_address,
    output logic [31:0]     o_next_address,
    output logic [1:0]      o_status,
    output logic            o_dest_write,
    output logic [4:0]      o_dest_index,
    output logic [31:0]     o_dest_value,
    output logic            o_mem_write,
    output logic [31:0]     o_mem_address
);

    // control
    logic            r_start_load;
    logic [XLEN-1:0] r_start_address;
    logic            r_e_valid, r_m_valid, r_o_valid;
    // payload
    logic [XLEN-1:0] r_pc;
    logic [XLEN-1:0] r_e_instr;
    t_exec           r_m, r_o;

    logic            out_free, m_done, m_free, e_adv, in_acc;
    logic            dm_busy;
    logic [XLEN-1:0] rf_rs1, rf_rs2, op_a, op_b;
    logic [XLEN-1:0] dm_rdata, m_value, sb_word, lane_mask;
    logic [4:0]      lane_shift;
    logic            m_is_store;
    t_exec           e_exec, m_final;
    t_rf_wr          rf_wr;
    t_dm_wr          dm_wr;

    // ---------------- handshake and pipeline advance ----------------
    assign out_free   = !r_o_valid || i_out_ready;
    assign m_done     = r_m_valid && out_free;
    assign m_free     = !r_m_valid || m_done;
    assign e_adv      = r_e_valid && m_free;
    assign o_in_ready = !dm_busy && (!r_e_valid || e_adv);
    assign in_acc     = i_in_valid && o_in_ready;

    // ---------------- configuration and program counter ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_address <= START_ADDR_RST;
            r_start_load    <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_start_address <= i_cfg_data;
            end
            r_start_load <= 1'b0;
        end
    end

    // PC loads start_address in the first cycle out of reset (clear pass is
    // running, so no item can be in execute yet); reset also returns
    // start_address to its reset value, so a written value never reaches the PC.
    always_ff @(posedge i_clk) begin
        if (r_start_load) begin
            r_pc <= r_start_address;
        end else if (e_adv) begin
            r_pc <= e_exec.next_address;
        end
    end

    // ---------------- register file, read at accept ----------------
    rvse_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_acc),
        .i_rs1_addr (i_instruction[19:15]),
        .i_rs2_addr (i_instruction[24:20]),
        .i_wr       (rf_wr),
        .o_rs1_data (rf_rs1),
        .o_rs2_data (rf_rs2)
    );

    // ---------------- execute stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (in_acc) begin
            r_e_valid <= 1'b1;
        end else if (e_adv) begin
            r_e_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_e_instr <= i_instruction;
        end
    end

    // The item in the memory stage has not written back yet; its result
    // (load data straight off the RAM port) overrides the register file.
    assign op_a = (r_m_valid && r_m.dest_write && (r_m.dest_index == r_e_instr[19:15]))
                  ? m_value : rf_rs1;
    assign op_b = (r_m_valid && r_m.dest_write && (r_m.dest_index == r_e_instr[24:20]))
                  ? m_value : rf_rs2;

    rvse_exec u_exec (
        .i_instruction (r_e_instr),
        .i_pc          (r_pc),
        .i_rs1_data    (op_a),
        .i_rs2_data    (op_b),
        .o_exec        (e_exec)
    );

    // ---------------- data memory, read as execute retires ----------------
    rvse_dmem u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (e_adv),
        .i_rd_addr (e_exec.mem_address[DMEM_AW+1:2]),
        .i_wr      (dm_wr),
        .o_rd_data (dm_rdata),
        .o_busy    (dm_busy)
    );

    // ---------------- memory stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (e_adv) begin
            r_m_valid <= 1'b1;
        end else if (m_done) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_adv) begin
            r_m <= e_exec;
        end
    end

    assign m_value = (r_m.mem_op == MOP_LW && r_m.dest_write) ? dm_rdata : r_m.dest_value;

    // byte store: replace lane mem_address[1:0] of the word just read
    assign lane_shift = {r_m.mem_address[1:0], 3'b000};
    assign lane_mask  = (~LANE_KEEP_MASK) << lane_shift;
    assign sb_word    = (dm_rdata & ~lane_mask) | ((r_m.store_data & BYTE_MASK) << lane_shift);
    assign m_is_store = (r_m.mem_op == MOP_SW) || (r_m.mem_op == MOP_SB);

    assign dm_wr.en   = m_done && m_is_store;
    assign dm_wr.addr = r_m.mem_address[DMEM_AW+1:2];
    assign dm_wr.data = (r_m.mem_op == MOP_SW) ? r_m.store_data : sb_word;

    assign rf_wr.en   = m_done && r_m.dest_write;
    assign rf_wr.addr = r_m.dest_index;
    assign rf_wr.data = m_value;

    always_comb begin
        m_final            = r_m;
        m_final.dest_value = m_value;
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (m_done) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_done) begin
            r_o <= m_final;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_instr_address = r_o.instr_address;
    assign o_next_address  = r_o.next_address;
    assign o_status        = r_o.status;
    assign o_dest_write    = r_o.dest_write;
    assign o_dest_index    = r_o.dest_index;
    assign o_dest_value    = r_o.dest_value;
    assign o_mem_write     = (r_o.mem_op == MOP_SW) || (r_o.mem_op == MOP_SB);
    assign o_mem_address   = r_o.mem_address;

    // ---------------- assertions ----------------
    `RVSE_ASSERT_COMB(a_no_store_in_clear, dm_busy, !dm_wr.en, "store during clearing pass")
    `RVSE_ASSERT_COMB(a_x0_never_written, rf_wr.en, rf_wr.addr != '0, "write to x0")
    `RVSE_ASSERT_COMB(a_fault_no_effect, r_o_valid && (r_o.status != ST_DONE), !o_dest_write && !o_mem_write && (o_next_address == o_instr_address), "faulting item changed state")
    `RVSE_ASSERT_NEXT(a_stall_holds_pipe, r_e_valid && r_m_valid && !out_free, r_e_valid && r_m_valid, "pipeline lost an item in a stall")

endmodule

// ----- verif/rv32i_subset_execute_retire_check.sv -----
// Result checker for rv32i_subset_execute: predicts each retired item from the
// accepted instruction words and compares it with the output channel. Uses rvse_pkg.
`timescale 1ns / 1ps

module rv32i_subset_execute_retire_check import rvse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_instruction,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_instr_address,
    input  logic [31:0] i_next_address,
    input  logic [1:0]  i_status,
    input  logic        i_dest_write,
    input  logic [4:0]  i_dest_index,
    input  logic [31:0] i_dest_value,
    input  logic        i_mem_write,
    input  logic [31:0] i_mem_address,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [XLEN-1:0]   instr_address;
        logic [XLEN-1:0]   next_address;
        t_status           status;
        logic              dest_write;
        logic [REG_AW-1:0] dest_index;
        logic [XLEN-1:0]   dest_value;
        logic              mem_write;
        logic [XLEN-1:0]   mem_address;
    } t_retire;

    logic [XLEN-1:0] start_addr_q;
    logic [XLEN-1:0] pc_q;
    logic [XLEN-1:0] regs [REGS];
    logic [XLEN-1:0] dmem [DATA_WORDS];
    t_retire         retire_q [$];
    int              fail_cnt;
    int              retired_cnt;

    // Executes one instruction against the shadow state and returns what retires.
    function automatic t_retire execute_instr(input logic [31:0] ins);
        t_retire            r;
        logic [6:0]         opc;
        logic [6:0]         f7;
        logic [2:0]         f3;
        logic [4:0]         rd;
        logic [4:0]         rs1;
        logic [4:0]         rs2;
        logic [XLEN-1:0]    a;
        logic [XLEN-1:0]    b;
        logic [XLEN-1:0]    imm_i;
        logic [XLEN-1:0]    imm_s;
        logic [XLEN-1:0]    imm_j;
        logic [XLEN-1:0]    imm_b;
        logic [XLEN-1:0]    tgt;
        logic [XLEN-1:0]    nxt;
        logic [XLEN-1:0]    val;
        logic [XLEN-1:0]    maddr;
        logic [XLEN-1:0]    word;
        logic [DMEM_AW-1:0] widx;
        logic               wr;
        logic               mw;
        t_status            st;

        opc   = ins[6:0];
        rd    = ins[11:7];
        f3    = ins[14:12];
        rs1   = ins[19:15];
        rs2   = ins[24:20];
        f7    = ins[31:25];
        a     = (rs1 == '0) ? '0 : regs[rs1];
        b     = (rs2 == '0) ? '0 : regs[rs2];
        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        nxt   = pc_q + INSTR_BYTES;
        st    = ST_DONE;
        val   = '0;
        maddr = '0;
        wr    = 1'b0;
        mw    = 1'b0;

        if (opc == OPC_OP_IMM && f3 == F3_ADDI) begin
            wr  = 1'b1;
            val = a + imm_i;
        end else if (opc == OPC_LUI) begin
            wr  = 1'b1;
            val = ins & UIMM_MASK;
        end else if (opc == OPC_AUIPC) begin
            wr  = 1'b1;
            val = pc_q + (ins & UIMM_MASK);
        end else if (opc == OPC_OP && f7 == F7_BASE && f3 == F3_XOR) begin
            wr  = 1'b1;
            val = a ^ b;
        end else if (opc == OPC_OP && f7 == F7_BASE && f3 == F3_SLTU) begin
            wr  = 1'b1;
            val = (a < b) ? 32'd1 : 32'd0;
        end else if (opc == OPC_JAL) begin
            tgt = pc_q + imm_j;
            if ((tgt & MISALIGN_BIT) != '0) begin
                st = ST_MISALIGNED;
            end else begin
                wr  = 1'b1;
                val = pc_q + INSTR_BYTES;
                nxt = tgt;
            end
        end else if (opc == OPC_JALR && f3 == F3_JALR) begin
            tgt = a + imm_i;
            if ((tgt & MISALIGN_BIT) != '0) begin
                st = ST_MISALIGNED;
            end else begin
                wr  = 1'b1;
                val = pc_q + INSTR_BYTES;
                nxt = tgt & PC_ALIGN_MASK;
            end
        end else if (opc == OPC_BRANCH && f3 == F3_BEQ) begin
            // alignment is checked on the target even when not taken
            tgt = pc_q + imm_b;
            if ((tgt & MISALIGN_BIT) != '0) st = ST_MISALIGNED;
            else if (a == b) nxt = tgt;
        end else if (opc == OPC_LOAD && f3 == F3_LW) begin
            maddr = a + imm_i;
            widx  = maddr[DMEM_AW+1:2];
            wr    = 1'b1;
            val   = dmem[widx];
        end else if (opc == OPC_STORE && f3 == F3_SW) begin
            maddr      = a + imm_s;
            widx       = maddr[DMEM_AW+1:2];
            dmem[widx] = b;
            mw         = 1'b1;
        end else if (opc == OPC_STORE && f3 == F3_SB) begin
            maddr = a + imm_s;
            widx  = maddr[DMEM_AW+1:2];
            word  = dmem[widx];
            word[{maddr[1:0], 3'b000} +: 8] = b[7:0];
            dmem[widx] = word;
            mw         = 1'b1;
        end else begin
            st = ST_UNSUPPORTED;
        end

        if (st != ST_DONE) begin
            nxt   = pc_q;
            wr    = 1'b0;
            val   = '0;
            rd    = '0;
            maddr = '0;
            mw    = 1'b0;
        end else if (wr) begin
            if (rd != '0) regs[rd] = val;
            else begin
                wr  = 1'b0;
                val = '0;
            end
        end else begin
            rd = '0;
        end

        r.instr_address = pc_q;
        r.next_address  = nxt;
        r.status        = st;
        r.dest_write    = wr;
        r.dest_index    = rd;
        r.dest_value    = val;
        r.mem_write     = mw;
        r.mem_address   = maddr;
        pc_q            = nxt;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_retire got;
        t_retire want;

        if (!i_rst_n) begin
            start_addr_q = START_ADDR_RST;
            pc_q         = start_addr_q;
            for (int i = 0; i < REGS; i++) regs[i] = '0;
            for (int i = 0; i < DATA_WORDS; i++) dmem[i] = '0;
            retire_q.delete();
            fail_cnt    = 0;
            retired_cnt = 0;
        end else begin
            // start_address only matters at reset; keep the copy anyway
            if (i_cfg_we) start_addr_q = i_cfg_data;
            if (i_in_valid && i_in_ready) retire_q.push_back(execute_instr(i_instruction));
            if (i_out_valid && i_out_ready) begin
                got = '{i_instr_address, i_next_address, t_status'(i_status), i_dest_write,
                        i_dest_index, i_dest_value, i_mem_write, i_mem_address};
                if (retire_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("result %0d arrived with nothing outstanding, pc=%h",
                                 retired_cnt, got.instr_address);
                    fail_cnt++;
                end else begin
                    want = retire_q.pop_front();
                    if (got !== want) begin
                        if (fail_cnt < 10) begin
                            $display("result %0d exp: pc=%h next=%h st=%0d wr=%b rd=%0d val=%h mw=%b ma=%h",
                                     retired_cnt, want.instr_address, want.next_address,
                                     want.status, want.dest_write, want.dest_index,
                                     want.dest_value, want.mem_write, want.mem_address);
                            $display("result %0d got: pc=%h next=%h st=%0d wr=%b rd=%0d val=%h mw=%b ma=%h",
                                     retired_cnt, got.instr_address, got.next_address,
                                     got.status, got.dest_write, got.dest_index,
                                     got.dest_value, got.mem_write, got.mem_address);
                        end
                        fail_cnt++;
                    end
                end
                retired_cnt++;
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= retire_q.size();
    end

endmodule

// ----- verif/rv32i_subset_execute_test.sv -----
// Testbench top for rv32i_subset_execute: drives instruction words and start_address
// writes, varies back-pressure, and gives the verdict. Uses rvse_pkg and the retire checker.
`timescale 1ns / 1ps

module rv32i_subset_execute_test;
    import rvse_pkg::*;

    localparam int RANDOM_PER_PHASE = 350;
    // wait after the last result before the verdict
    localparam int SETTLE_CYCLES    = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_instruction;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_instr_address;
    logic [31:0] o_next_address;
    logic [1:0]  o_status;
    logic        o_dest_write;
    logic [4:0]  o_dest_index;
    logic [31:0] o_dest_value;
    logic        o_mem_write;
    logic [31:0] o_mem_address;

    // idle odds in percent, per cycle, for each side
    int send_idle_pct;
    int recv_idle_pct;
    // items left in the current gap-free stretch of the sender
    int gap_free_left;
    int fail_count;
    int pending;

    rv32i_subset_execute u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_instruction   (i_instruction),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_instr_address (o_instr_address),
        .o_next_address  (o_next_address),
        .o_status        (o_status),
        .o_dest_write    (o_dest_write),
        .o_dest_index    (o_dest_index),
        .o_dest_value    (o_dest_value),
        .o_mem_write     (o_mem_write),
        .o_mem_address   (o_mem_address)
    );

    rv32i_subset_execute_retire_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_instruction   (i_instruction),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_instr_address (o_instr_address),
        .i_next_address  (o_next_address),
        .i_status        (o_status),
        .i_dest_write    (o_dest_write),
        .i_dest_index    (o_dest_index),
        .i_dest_value    (o_dest_value),
        .i_mem_write     (o_mem_write),
        .i_mem_address   (o_mem_address),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: the slowest legal run (clearing pass plus ~1100 items under
    // heavy stalls) is well under a tenth of this.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Instruction encoders, RV32I base formats
    // ---------------------------------------------------------------
    function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [4:0] rs1,
                                          input logic [11:0] imm);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_u(input logic [6:0] opc, input logic [4:0] rd,
                                          input logic [19:0] imm);
        return {imm, rd, opc};
    endfunction

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [4:0] rs1,
                                          input logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, OPC_OP};
    endfunction

    function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [4:0] rs2, input logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    function automatic logic [31:0] enc_b(input logic [4:0] rs1, input logic [4:0] rs2,
                                          input logic [12:0] imm);
        return {imm[12], imm[10:5], rs2, rs1, F3_BEQ, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    // ---------------------------------------------------------------
    // Random field pickers
    // ---------------------------------------------------------------
    // Mostly x0..x7 so results feed the next few items (forwarding paths).
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 99) < 70) return 5'($urandom_range(0, 7));
        return 5'($urandom_range(0, 31));
    endfunction

    // Load/store base: x0 often, so addresses stay in a small window and
    // loads hit words that stores just wrote.
    function automatic logic [4:0] pick_base();
        if ($urandom_range(0, 99) < 60) return 5'd0;
        return pick_reg();
    endfunction

    // Small offsets around zero; negative ones wrap to the top of memory.
    function automatic logic [11:0] pick_mem_off();
        if ($urandom_range(0, 99) < 75) return 12'($urandom_range(0, 255)) - 12'd128;
        return 12'($urandom);
    endfunction

    // One random item: mostly well-formed supported instructions with random
    // fields, some with broken funct fields, some raw noise.
    function automatic logic [31:0] random_instr();
        int          kind;
        logic [31:0] w;
        logic [4:0]  r1;
        logic [11:0] imm12;

        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            w = enc_i(OPC_OP_IMM, F3_ADDI, pick_reg(), pick_reg(), 12'($urandom));
        end else if (kind < 18) begin
            w = enc_u(OPC_LUI, pick_reg(), 20'($urandom));
        end else if (kind < 23) begin
            w = enc_u(OPC_AUIPC, pick_reg(), 20'($urandom));
        end else if (kind < 32) begin
            w = enc_r(F7_BASE, F3_XOR, pick_reg(), pick_reg(), pick_reg());
        end else if (kind < 41) begin
            w = enc_r(F7_BASE, F3_SLTU, pick_reg(), pick_reg(), pick_reg());
        end else if (kind < 48) begin
            // word-aligned near jumps mostly; otherwise any even offset
            if ($urandom_range(0, 99) < 80)
                w = enc_j(pick_reg(), 21'(($urandom_range(0, 255) - 128) * 4));
            else
                w = enc_j(pick_reg(), 21'($urandom));
        end else if (kind < 54) begin
            if ($urandom_range(0, 99) < 50) begin
                // aligned absolute target, bit 0 random (cleared by the jump),
                // bit 1 set now and then for the misaligned case
                imm12 = 12'($urandom_range(0, 1023) * 4) | 12'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < 15) imm12 = imm12 | 12'd2;
                w = enc_i(OPC_JALR, F3_JALR, pick_reg(), 5'd0, imm12);
            end else begin
                w = enc_i(OPC_JALR, F3_JALR, pick_reg(), pick_reg(), 12'($urandom));
            end
        end else if (kind < 64) begin
            r1 = pick_reg();
            if ($urandom_range(0, 99) < 80)
                w = enc_b(r1, ($urandom_range(0, 99) < 30) ? r1 : pick_reg(),
                          13'(($urandom_range(0, 63) - 32) * 4));
            else
                w = enc_b(r1, pick_reg(), 13'($urandom));
        end else if (kind < 74) begin
            w = enc_i(OPC_LOAD, F3_LW, pick_reg(), pick_base(), pick_mem_off());
        end else if (kind < 83) begin
            w = enc_s(F3_SW, pick_base(), pick_reg(), pick_mem_off());
        end else if (kind < 91) begin
            w = enc_s(F3_SB, pick_base(), pick_reg(), pick_mem_off());
        end else if (kind < 96) begin
            // known opcode, random funct fields: mostly unsupported encodings
            w = $urandom;
            case ($urandom_range(0, 5))
                0:       w[6:0] = OPC_OP_IMM;
                1:       w[6:0] = OPC_OP;
                2:       w[6:0] = OPC_LOAD;
                3:       w[6:0] = OPC_STORE;
                4:       w[6:0] = OPC_JALR;
                default: w[6:0] = OPC_BRANCH;
            endcase
        end else begin
            w = $urandom;
        end
        return w;
    endfunction

    // ---------------------------------------------------------------
    // Drivers (inputs change on the falling edge)
    // ---------------------------------------------------------------
    // Presents one item, holds it until accepted, then maybe idles. Called and
    // returns at a falling edge; valid stays high when no gap follows.
    task automatic send_instr(input logic [31:0] word);
        i_in_valid    <= 1'b1;
        i_instruction <= word;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (gap_free_left > 0) begin
            gap_free_left--;
        end else begin
            if ($urandom_range(0, 49) == 0) gap_free_left = 16;
            while ($urandom_range(0, 99) < send_idle_pct) begin
                i_in_valid    <= 1'b0;
                i_instruction <= $urandom;
                @(negedge i_clk);
            end
        end
    endtask

    // Sender holds off until every outstanding item has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_start_address(input logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    // Receiver: random ready per cycle, with occasional always-ready stretches.
    initial begin : sink
        int quiet_left;

        quiet_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet_left > 0) begin
                quiet_left--;
                i_out_ready <= 1'b1;
            end else begin
                if ($urandom_range(0, 199) == 0) quiet_left = 40;
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and verdict
    // ---------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] start_values [3];
        int          send_pcts [3];
        int          recv_pcts [3];

        start_values  = '{32'h0000_0000, $urandom, 32'h8000_0000};
        send_pcts     = '{21, 58, 0};
        recv_pcts     = '{58, 21, 0};
        send_idle_pct = send_pcts[0];
        recv_idle_pct = recv_pcts[0];
        gap_free_left = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_instruction = '0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // start_address only takes effect at reset, which never recurs; the
        // writes must still leave execution alone. The clearing pass after
        // reset just holds off the first item through the handshake.
        write_start_address(32'hFFFF_FFFF);

        // Directed: every operation, field extremes and the corner cases.
        send_instr(enc_i(OPC_OP_IMM, F3_ADDI, 5'd1, 5'd0, 12'hFFF));  // x1 = -1
        send_instr(enc_i(OPC_OP_IMM, F3_ADDI, 5'd2, 5'd0, 12'h7FF));  // x2 = 2047
        send_instr(enc_u(OPC_LUI, 5'd3, 20'hFFFFF));
        send_instr(enc_u(OPC_AUIPC, 5'd4, 20'h80000));
        send_instr(enc_r(F7_BASE, F3_XOR, 5'd5, 5'd1, 5'd2));
        send_instr(enc_r(F7_BASE, F3_SLTU, 5'd6, 5'd2, 5'd1));        // true
        send_instr(enc_r(F7_BASE, F3_SLTU, 5'd7, 5'd1, 5'd2));        // false
        send_instr(enc_i(OPC_OP_IMM, F3_ADDI, 5'd0, 5'd1, 12'd5));    // x0 write dropped
        send_instr(enc_s(F3_SW, 5'd0, 5'd1, 12'd0));
        // byte stores into lanes 1, 3 and 0 of the same word
        send_instr(enc_s(F3_SB, 5'd0, 5'd2, 12'd1));
        send_instr(enc_s(F3_SB, 5'd0, 5'd4, 12'd3));
        send_instr(enc_s(F3_SB, 5'd0, 5'd0, 12'd0));
        send_instr(enc_i(OPC_LOAD, F3_LW, 5'd8, 5'd0, 12'd0));        // right after stores
        send_instr(enc_s(F3_SW, 5'd0, 5'd5, 12'hFFC));                // wraps to last word
        send_instr(enc_i(OPC_LOAD, F3_LW, 5'd9, 5'd3, 12'h7FC));      // high address wraps
        send_instr(enc_i(OPC_LOAD, F3_LW, 5'd10, 5'd0, 12'hFFC));
        send_instr(enc_j(5'd11, 21'd8));
        send_instr(enc_j(5'd12, 21'd6));                              // misaligned
        send_instr(enc_i(OPC_JALR, F3_JALR, 5'd13, 5'd0, 12'h101));   // bit 0 cleared
        send_instr(enc_i(OPC_JALR, F3_JALR, 5'd14, 5'd0, 12'h102));   // misaligned
        send_instr(enc_b(5'd0, 5'd0, 13'd16));                        // taken
        send_instr(enc_b(5'd1, 5'd0, 13'd8));                         // not taken
        send_instr(enc_b(5'd1, 5'd0, 13'd6));                         // not taken, misaligned
        send_instr(32'h0000_0000);                                    // unsupported
        send_instr(32'hFFFF_FFFF);
        send_instr(enc_r(7'h20, F3_XOR, 5'd15, 5'd1, 5'd2));          // bad funct7
        send_instr(enc_j(5'd16, 21'h100000));                         // PC wraps below zero

        // Random phases: sender-light, receiver-light, then full rate.
        for (int ph = 0; ph < 3; ph++) begin
            wait_for_results();
            write_start_address(start_values[ph]);
            send_idle_pct = send_pcts[ph];
            recv_idle_pct = recv_pcts[ph];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n == RANDOM_PER_PHASE / 2) wait_for_results();
                send_instr(random_instr());
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
